// ----- design/apc_pkg.sv -----
// Shared types, constants and fixed-point helpers for the cell update block.
// Q8.24 signed arithmetic with saturation; used by every design file.
`timescale 1ns / 1ps
`default_nettype none
package apc_pkg;
  localparam int W  = 32;
  localparam int F  = 24;
  localparam int XW = W - F;

  typedef logic signed [W-1:0]   word_t;
  typedef logic        [W-1:0]   uword_t;
  typedef logic signed [2*W-1:0] prod_t;

  localparam word_t MAXV = {1'b0, {(W-1){1'b1}}};
  localparam word_t MINV = {1'b1, {(W-1){1'b0}}};
  localparam word_t ONE  = (F < W - 1) ? word_t'(64'sd1 <<< F) : MAXV;
  localparam prod_t HALF = prod_t'(64'sd1 <<< (F - 1));

  typedef enum logic [2:0] {
    REG_ALPHA, REG_DT, REG_KK, REG_A, REG_B, REG_EPS, REG_M1, REG_M2
  } reg_idx_t;

  localparam word_t RST_ALPHA = word_t'(0);
  localparam word_t RST_DT    = word_t'(0);
  localparam word_t RST_KK    = word_t'(134217728);
  localparam word_t RST_A     = word_t'(1677722);
  localparam word_t RST_B     = word_t'(1677722);
  localparam word_t RST_EPS   = word_t'(167772);
  localparam word_t RST_M1    = word_t'(1174405);
  localparam word_t RST_M2    = word_t'(5033165);

  typedef struct packed {
    word_t alpha;
    word_t dt;
    word_t kk;
    word_t a;
    word_t b;
    word_t eps;
    word_t m1;
    word_t m2;
  } cfg_t;

  typedef struct packed {
    logic  clip;
    word_t val;
  } sres_t;

  typedef struct packed {
    word_t enew;
    word_t r;
    word_t h;
    logic  clip;
  } side_t;

  typedef struct packed {
    word_t num;
    word_t den;
    side_t side;
  } front_t;

  function automatic sres_t sat_ext(logic signed [W:0] x);
    sres_t s;
    if (x[W] != x[W-1]) begin
      s.clip = 1'b1;
      s.val  = x[W] ? MINV : MAXV;
    end else begin
      s.clip = 1'b0;
      s.val  = x[W-1:0];
    end
    return s;
  endfunction

  function automatic sres_t sadd(word_t a, word_t b);
    logic signed [W:0] x;
    x = {a[W-1], a} + {b[W-1], b};
    return sat_ext(x);
  endfunction

  function automatic sres_t ssub(word_t a, word_t b);
    logic signed [W:0] x;
    x = {a[W-1], a} - {b[W-1], b};
    return sat_ext(x);
  endfunction

  function automatic prod_t mul(word_t a, word_t b);
    return prod_t'(a) * prod_t'(b);
  endfunction

  // round half away from zero, then clip to the word range
  function automatic sres_t rnd_sat(prod_t p);
    prod_t q;
    prod_t s;
    sres_t r;
    q = p + (p[2*W-1] ? (HALF - prod_t'(1)) : HALF);
    s = q >>> F;
    if (s[2*W-1:W-1] == '0 || s[2*W-1:W-1] == '1) begin
      r.clip = 1'b0;
      r.val  = s[W-1:0];
    end else begin
      r.clip = 1'b1;
      r.val  = s[2*W-1] ? MINV : MAXV;
    end
    return r;
  endfunction
endpackage
`default_nettype wire

// ----- design/apc_if.sv -----
// Valid/ready channel interfaces for cell items and result items.
// Depends on apc_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface apc_in_if;
  logic              valid;
  logic              ready;
  apc_pkg::word_t    e_center;
  apc_pkg::word_t    e_left;
  apc_pkg::word_t    e_right;
  apc_pkg::word_t    e_up;
  apc_pkg::word_t    e_down;
  apc_pkg::word_t    r_center;
  modport source (output valid, e_center, e_left, e_right, e_up, e_down, r_center,
                  input ready);
  modport sink   (input valid, e_center, e_left, e_right, e_up, e_down, r_center,
                  output ready);
endinterface

interface apc_out_if;
  logic              valid;
  logic              ready;
  apc_pkg::word_t    e_next;
  apc_pkg::word_t    r_next;
  logic              saturated;
  modport source (output valid, e_next, r_next, saturated, input ready);
  modport sink   (input valid, e_next, r_next, saturated, output ready);
endinterface
`default_nettype wire

// ----- design/aliev_panfilov_cell_update.sv -----
// Aliev-Panfilov explicit Euler cell update, top level.
// Holds the parameter registers and joins front, divider and tail pipelines.
// Depends on apc_pkg, apc_if, apc_front, apc_div, apc_tail.
//
// Usage:
//   cell_in carries one mesh cell item (e_center, four neighbors, r_center);
//   cell_out returns one result item (e_next, r_next, saturated) per item,
//   in order. Parameters are written through cfg_we/cfg_index/cfg_data while
//   no item is in flight.
//   Stages: 10 front stages, 34 divider stages (one quotient bit per step
//   stage between its input and output registers), 6 tail stages.
//   Throughput: one item per cycle while cell_out is not stalled; every
//   stage is registered and the divider is fully unrolled into stages.
//   Reset: all valid bits clear, parameters take their default values.
//   Stall: while cell_out is valid and not ready the whole pipeline holds
//   and cell_in.ready drops; nothing is lost or repeated. Bubbles hold in
//   place as well.
`timescale 1ns / 1ps
`default_nettype none
module aliev_panfilov_cell_update (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire apc_pkg::reg_idx_t     cfg_index,
  input  wire apc_pkg::word_t        cfg_data,
  apc_in_if.sink                     cell_in,
  apc_out_if.source                  cell_out
);
  import apc_pkg::*;

  cfg_t   cfg;
  logic   en;
  logic   f_v, d_v;
  front_t f_d;
  word_t  d_q;
  logic   d_clip;
  side_t  d_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alpha <= RST_ALPHA;
      cfg.dt    <= RST_DT;
      cfg.kk    <= RST_KK;
      cfg.a     <= RST_A;
      cfg.b     <= RST_B;
      cfg.eps   <= RST_EPS;
      cfg.m1    <= RST_M1;
      cfg.m2    <= RST_M2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ALPHA: cfg.alpha <= cfg_data;
        REG_DT:    cfg.dt    <= cfg_data;
        REG_KK:    cfg.kk    <= cfg_data;
        REG_A:     cfg.a     <= cfg_data;
        REG_B:     cfg.b     <= cfg_data;
        REG_EPS:   cfg.eps   <= cfg_data;
        REG_M1:    cfg.m1    <= cfg_data;
        REG_M2:    cfg.m2    <= cfg_data;
        default:   cfg       <= cfg;
      endcase
    end
  end

  assign en            = !cell_out.valid || cell_out.ready;
  assign cell_in.ready = en;

  apc_front u_front (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .cfg   (cfg),
    .in_v  (cell_in.valid),
    .c_in  (cell_in.e_center),
    .el_in (cell_in.e_left),
    .er_in (cell_in.e_right),
    .eu_in (cell_in.e_up),
    .ed_in (cell_in.e_down),
    .r_in  (cell_in.r_center),
    .out_v (f_v),
    .out_d (f_d)
  );

  apc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .in_v  (f_v),
    .in_d  (f_d),
    .out_v (d_v),
    .q     (d_q),
    .qclip (d_clip),
    .side  (d_side)
  );

  apc_tail u_tail (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .cfg     (cfg),
    .in_v    (d_v),
    .q       (d_q),
    .qclip   (d_clip),
    .side    (d_side),
    .out_v   (cell_out.valid),
    .e_out   (cell_out.e_next),
    .r_out   (cell_out.r_next),
    .sat_out (cell_out.saturated)
  );

  a_reset_empty: assert property (@(posedge clk) rst |=> !cell_out.valid)
    else $error("result valid after reset");

  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !cell_in.ready |-> (cell_out.valid && !cell_out.ready))
    else $error("input blocked without output stall");

  a_dt_write: assert property (@(posedge clk) disable iff (rst)
    (cfg_we && cfg_index == REG_DT) |=> cfg.dt == $past(cfg_data))
    else $error("time step register not written");
endmodule
`default_nettype wire

// ----- design/apc_front.sv -----
// Front pipeline: Laplacian, reaction term, new excitation, and the
// numerator/divisor/h terms of the recovery update. Depends on apc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module apc_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire apc_pkg::cfg_t   cfg,
  input  wire logic            in_v,
  input  wire apc_pkg::word_t  c_in,
  input  wire apc_pkg::word_t  el_in,
  input  wire apc_pkg::word_t  er_in,
  input  wire apc_pkg::word_t  eu_in,
  input  wire apc_pkg::word_t  ed_in,
  input  wire apc_pkg::word_t  r_in,
  output logic                 out_v,
  output apc_pkg::front_t      out_d
);
  import apc_pkg::*;

  logic [9:1] v;

  // stage 1
  word_t c1, r1, slr1, sud1, cc1, t1_1, t2_1, hb0_1, den1, nr1;
  prod_t pkc1, pmr1, pcr1;
  logic  cl1;
  // stage 2
  word_t c2, r2, t1_2, t2_2, nr2, den2, p1_2, m_2, p4_2, sn2, c4_2, hb2;
  logic  cl2;
  // stage 3
  word_t c3, r3, t2_3, nr3, den3, m_3, p4_3, lap3;
  prod_t pa3, pk3;
  logic  cl3;
  // stage 4
  word_t c4, r4, t2_4, nr4, den4, m_4, p4_4, p2_4, k4;
  prod_t pl4;
  logic  cl4;
  // stage 5
  word_t c5, r5, den5, m_5, p4_5, a5, h5;
  prod_t pb5;
  logic  cl5;
  // stage 6
  word_t r6, den6, m_6, p4_6, h6, p3_6, e1_6;
  logic  cl6;
  // stage 7
  word_t r7, den7, m_7, h7, e1_7, react7;
  logic  cl7;
  // stage 8
  word_t r8, den8, m_8, h8, e1_8;
  prod_t pd8;
  logic  cl8;
  // stage 9
  word_t r9, den9, m_9, h9, e1_9, d9;
  logic  cl9;

  sres_t s1_lr, s1_ud, s1_cc, s1_t1, s1_t2, s1_hb, s1_den, s1_nr;
  sres_t s2_p1, s2_m, s2_p4, s2_sn, s2_c4, s2_hb;
  sres_t s3_lap, s4_p2, s4_k, s5_a, s5_h, s6_p3, s6_e1, s7_re, s9_d, s10_e;

  always_comb begin
    s1_lr  = sadd(el_in, er_in);
    s1_ud  = sadd(eu_in, ed_in);
    s1_cc  = sadd(c_in, c_in);
    s1_t1  = ssub(c_in, cfg.a);
    s1_t2  = ssub(c_in, ONE);
    s1_hb  = ssub(c_in, cfg.b);
    s1_den = sadd(c_in, cfg.m2);
    s1_nr  = ssub(word_t'(0), r_in);
    s2_p1  = rnd_sat(pkc1);
    s2_m   = rnd_sat(pmr1);
    s2_p4  = rnd_sat(pcr1);
    s2_sn  = sadd(slr1, sud1);
    s2_c4  = sadd(cc1, cc1);
    s2_hb  = ssub(hb0_1, ONE);
    s3_lap = ssub(sn2, c4_2);
    s4_p2  = rnd_sat(pa3);
    s4_k   = rnd_sat(pk3);
    s5_a   = rnd_sat(pl4);
    s5_h   = ssub(nr4, k4);
    s6_p3  = rnd_sat(pb5);
    s6_e1  = sadd(c5, a5);
    s7_re  = sadd(p3_6, p4_6);
    s9_d   = rnd_sat(pd8);
    s10_e  = ssub(e1_9, d9);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v     <= '0;
      out_v <= 1'b0;
    end else if (en) begin
      v     <= {v[8:1], in_v};
      out_v <= v[9];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1 <= c_in; r1 <= r_in;
      slr1 <= s1_lr.val; sud1 <= s1_ud.val; cc1 <= s1_cc.val;
      t1_1 <= s1_t1.val; t2_1 <= s1_t2.val; hb0_1 <= s1_hb.val;
      den1 <= s1_den.val; nr1 <= s1_nr.val;
      pkc1 <= mul(cfg.kk, c_in); pmr1 <= mul(cfg.m1, r_in); pcr1 <= mul(c_in, r_in);
      cl1 <= s1_lr.clip | s1_ud.clip | s1_cc.clip | s1_t1.clip | s1_t2.clip |
             s1_hb.clip | s1_den.clip | s1_nr.clip;

      c2 <= c1; r2 <= r1; t1_2 <= t1_1; t2_2 <= t2_1; nr2 <= nr1; den2 <= den1;
      p1_2 <= s2_p1.val; m_2 <= s2_m.val; p4_2 <= s2_p4.val;
      sn2 <= s2_sn.val; c4_2 <= s2_c4.val; hb2 <= s2_hb.val;
      cl2 <= cl1 | s2_p1.clip | s2_m.clip | s2_p4.clip | s2_sn.clip | s2_c4.clip |
             s2_hb.clip;

      c3 <= c2; r3 <= r2; t2_3 <= t2_2; nr3 <= nr2; den3 <= den2; m_3 <= m_2;
      p4_3 <= p4_2; lap3 <= s3_lap.val;
      pa3 <= mul(p1_2, t1_2); pk3 <= mul(p1_2, hb2);
      cl3 <= cl2 | s3_lap.clip;

      c4 <= c3; r4 <= r3; t2_4 <= t2_3; nr4 <= nr3; den4 <= den3; m_4 <= m_3;
      p4_4 <= p4_3; p2_4 <= s4_p2.val; k4 <= s4_k.val;
      pl4 <= mul(cfg.alpha, lap3);
      cl4 <= cl3 | s4_p2.clip | s4_k.clip;

      c5 <= c4; r5 <= r4; den5 <= den4; m_5 <= m_4; p4_5 <= p4_4;
      a5 <= s5_a.val; h5 <= s5_h.val;
      pb5 <= mul(p2_4, t2_4);
      cl5 <= cl4 | s5_a.clip | s5_h.clip;

      r6 <= r5; den6 <= den5; m_6 <= m_5; p4_6 <= p4_5; h6 <= h5;
      p3_6 <= s6_p3.val; e1_6 <= s6_e1.val;
      cl6 <= cl5 | s6_p3.clip | s6_e1.clip;

      r7 <= r6; den7 <= den6; m_7 <= m_6; h7 <= h6; e1_7 <= e1_6;
      react7 <= s7_re.val;
      cl7 <= cl6 | s7_re.clip;

      r8 <= r7; den8 <= den7; m_8 <= m_7; h8 <= h7; e1_8 <= e1_7;
      pd8 <= mul(cfg.dt, react7);
      cl8 <= cl7;

      r9 <= r8; den9 <= den8; m_9 <= m_8; h9 <= h8; e1_9 <= e1_8;
      d9 <= s9_d.val;
      cl9 <= cl8 | s9_d.clip;

      out_d.num       <= m_9;
      out_d.den       <= den9;
      out_d.side.enew <= s10_e.val;
      out_d.side.r    <= r9;
      out_d.side.h    <= h9;
      out_d.side.clip <= cl9 | s10_e.clip;
    end
  end
endmodule
`default_nettype wire

// ----- design/apc_div.sv -----
// Pipelined restoring divider: (num << F) / den, truncated, saturated,
// one quotient bit per step stage; carries side data along. Depends on apc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module apc_div (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_v,
  input  wire apc_pkg::front_t  in_d,
  output logic                  out_v,
  output apc_pkg::word_t        q,
  output logic                  qclip,
  output apc_pkg::side_t        side
);
  import apc_pkg::*;

  typedef struct packed {
    logic   neg;
    logic   zero;
    logic   ovf;
    logic   npos;
    logic   nneg;
    uword_t du;
    side_t  side;
  } dctl_t;

  logic   v    [0:W];
  uword_t rem  [0:W];
  uword_t nlo  [0:W];
  uword_t qb   [0:W];
  dctl_t  ctl  [0:W];

  uword_t nu, du;
  logic   ovf;

  always_comb begin
    nu  = in_d.num[W-1] ? uword_t'(-in_d.num) : uword_t'(in_d.num);
    du  = in_d.den[W-1] ? uword_t'(-in_d.den) : uword_t'(in_d.den);
    ovf = {{XW{1'b0}}, nu} >= {du, {XW{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]       <= nu >> XW;
      nlo[0]       <= nu << F;
      qb[0]        <= '0;
      ctl[0].neg   <= in_d.num[W-1] ^ in_d.den[W-1];
      ctl[0].zero  <= (in_d.den == '0);
      ctl[0].ovf   <= ovf;
      ctl[0].npos  <= !in_d.num[W-1] && (in_d.num != '0);
      ctl[0].nneg  <= in_d.num[W-1];
      ctl[0].du    <= du;
      ctl[0].side  <= in_d.side;
    end
  end

  for (genvar k = 0; k < W; k++) begin : g_step
    logic [W:0] trial;
    logic       ge;
    always_comb begin
      trial = {rem[k], nlo[k][W-1]};
      ge    = trial >= {1'b0, ctl[k].du};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? uword_t'(trial - {1'b0, ctl[k].du}) : trial[W-1:0];
        nlo[k+1] <= nlo[k] << 1;
        qb[k+1]  <= {qb[k][W-2:0], ge};
        ctl[k+1] <= ctl[k];
      end
    end
  end

  sres_t fin;
  uword_t qm;

  always_comb begin
    qm = qb[W];
    if (ctl[W].zero) begin
      fin.clip = 1'b1;
      fin.val  = ctl[W].npos ? MAXV : (ctl[W].nneg ? MINV : word_t'(0));
    end else if (ctl[W].ovf) begin
      fin.clip = 1'b1;
      fin.val  = ctl[W].neg ? MINV : MAXV;
    end else if (ctl[W].neg) begin
      fin.clip = qm > uword_t'(MINV);
      fin.val  = fin.clip ? MINV : word_t'(-qm);
    end else begin
      fin.clip = qm > uword_t'(MAXV);
      fin.val  = fin.clip ? MAXV : word_t'(qm);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= v[W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q     <= fin.val;
      qclip <= fin.clip;
      side  <= ctl[W].side;
    end
  end
endmodule
`default_nettype wire

// ----- design/apc_tail.sv -----
// Tail pipeline: recovery rate g, dt*g*h and the new recovery value;
// the last stage is the output register. Depends on apc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module apc_tail (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire apc_pkg::cfg_t   cfg,
  input  wire logic            in_v,
  input  wire apc_pkg::word_t  q,
  input  wire logic            qclip,
  input  wire apc_pkg::side_t  side,
  output logic                 out_v,
  output apc_pkg::word_t       e_out,
  output apc_pkg::word_t       r_out,
  output logic                 sat_out
);
  import apc_pkg::*;

  logic [5:1] v;
  word_t g1, e1, r1, h1;
  logic  cl1;
  prod_t pg2;
  word_t e2, r2, h2;
  logic  cl2;
  word_t gg3, e3, r3, h3;
  logic  cl3;
  prod_t pz4;
  word_t e4, r4;
  logic  cl4;
  word_t z5, e5, r5;
  logic  cl5;

  sres_t s1_g, s3_g, s5_z, s6_r;

  always_comb begin
    s1_g = sadd(cfg.eps, q);
    s3_g = rnd_sat(pg2);
    s5_z = rnd_sat(pz4);
    s6_r = sadd(r5, z5);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v     <= '0;
      out_v <= 1'b0;
    end else if (en) begin
      v     <= {v[4:1], in_v};
      out_v <= v[5];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g1 <= s1_g.val; e1 <= side.enew; r1 <= side.r; h1 <= side.h;
      cl1 <= side.clip | qclip | s1_g.clip;

      pg2 <= mul(cfg.dt, g1); e2 <= e1; r2 <= r1; h2 <= h1; cl2 <= cl1;

      gg3 <= s3_g.val; e3 <= e2; r3 <= r2; h3 <= h2; cl3 <= cl2 | s3_g.clip;

      pz4 <= mul(gg3, h3); e4 <= e3; r4 <= r3; cl4 <= cl3;

      z5 <= s5_z.val; e5 <= e4; r5 <= r4; cl5 <= cl4 | s5_z.clip;

      e_out   <= e5;
      r_out   <= s6_r.val;
      sat_out <= cl5 | s6_r.clip;
    end
  end
endmodule
`default_nettype wire
